FILE: sv/js3d_pkg.sv
// js3d_pkg: shared constants, types and helpers for the 3d jacobi stencil sweep
// used by jacobi_stencil_3d_sweep; depends on nothing

package js3d_pkg;

    // grid limits and field widths
    localparam int MAX_X      = 64;
    localparam int MAX_Y      = 64;
    localparam int MAX_Z      = 64;
    localparam int VALUE_BITS = 32;
    localparam int XW         = $clog2(MAX_X);
    localparam int YW         = $clog2(MAX_Y);
    localparam int ZW         = $clog2(MAX_Z);
    localparam int SIZE_W     = 7;
    localparam int FACE_W     = 6;
    localparam int CHANGE_W   = 31;
    localparam int SRC_W      = 31;
    localparam int CFG_W      = 31;
    localparam int CFG_IDX_W  = 3;

    // plane window: two planes of MAX_X * MAX_Y points
    localparam int WIN_DEPTH  = 2 * MAX_X * MAX_Y;
    localparam int WIN_AW     = $clog2(WIN_DEPTH);

    // reciprocal of three, scaled by 2^20, for 18-bit dividends
    localparam int            DIV3_SHIFT = 20;
    localparam logic [19:0]   DIV3_RECIP = 20'd349526;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_SIZE = 3'd0,
        REG_Y_SIZE = 3'd1,
        REG_Z_SIZE = 3'd2,
        REG_FACES  = 3'd3,
        REG_SOURCE = 3'd4
    } js3d_reg_t;

    // per-item sideband carried down the arithmetic pipeline
    typedef struct packed {
        logic          clr;
        logic          hit;
        logic          last;
        logic [XW-1:0] px;
        logic [YW-1:0] py;
        logic [ZW-1:0] pz;
    } js3d_meta_t;

    // limit a size register to 3..hi
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] r;
        if (s < SIZE_W'(3))
            r = SIZE_W'(3);
        else if (s > hi)
            r = hi;
        else
            r = s;
        return r;
    endfunction

    // one base-2^16 digit of a division by three: returns {quotient, remainder}
    function automatic logic [17:0] div3_step(input logic [1:0]  rem_in,
                                              input logic [15:0] digit);
        logic [17:0] n;
        logic [37:0] prod;
        logic [15:0] q;
        logic [17:0] back;
        n    = {rem_in, digit};
        prod = n * DIV3_RECIP;
        q    = prod[DIV3_SHIFT+15:DIV3_SHIFT];
        back = n - {1'b0, q, 1'b0} - {2'b0, q};
        return {q, back[1:0]};
    endfunction

endpackage

FILE: sv/js3d_ram.sv
// js3d_ram: generic synchronous ram, one write port and two registered read ports
// read-first on a same-address write; depends on nothing

module js3d_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 8192,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re0,
    input  logic [AW-1:0]    raddr0,
    output logic [WIDTH-1:0] rdata0,
    input  logic             re1,
    input  logic [AW-1:0]    raddr1,
    output logic [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    // storage with registered reads
    always_ff @(posedge clk)
    begin
        if (re0)
            rdata0 <= mem[raddr0];
        if (re1)
            rdata1 <= mem[raddr1];
        if (we)
            mem[waddr] <= wdata;
    end

endmodule

FILE: sv/jacobi_stencil_3d_sweep.sv
// jacobi_stencil_3d_sweep: streamed 7-point jacobi update over a 3d grid
// depends on js3d_pkg and js3d_ram (two identical copies of the plane window)
//
//   channel | signals                                   | beat moves
//   --------+-------------------------------------------+--------------------------
//   in      | in_valid, in_ready, old_value, sweep_start | one old grid point
//   out     | out_valid, out_ready, new_value, point_*,  | one updated point
//           | abs_change, max_change, last_of_sweep      |
//   cfg     | cfg_write, cfg_index, cfg_data             | one register write
//
// one point per cycle; a result passes the stage registers and the output register
// after the beat that completes its stencil. the centre of each point is read one beat
// ahead from window port b1; when a point does not follow on in scan order (first beat
// after reset, a sweep restart) that read is redone and the input waits for it.
// the pipeline stalls only when a result meets a full output register.
// reset clears control state only; the window needs no clearing pass.

module jacobi_stencil_3d_sweep (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [js3d_pkg::VALUE_BITS-1:0] old_value,
    input  logic                              sweep_start,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [js3d_pkg::VALUE_BITS-1:0] new_value,
    output logic [js3d_pkg::XW-1:0]           point_x,
    output logic [js3d_pkg::YW-1:0]           point_y,
    output logic [js3d_pkg::ZW-1:0]           point_z,
    output logic [js3d_pkg::CHANGE_W-1:0]     abs_change,
    output logic [js3d_pkg::CHANGE_W-1:0]     max_change,
    output logic                              last_of_sweep,
    input  logic                              cfg_write,
    input  logic [js3d_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [js3d_pkg::CFG_W-1:0]        cfg_data
);

    import js3d_pkg::*;

    localparam logic signed [35:0] W_BIAS  = 36'sd25769803776;
    localparam logic signed [34:0] Q_BIAS  = 35'sd8589934592;
    localparam logic signed [34:0] V_MAX   = 35'sd2147483647;
    localparam logic signed [34:0] V_MIN   = -35'sd2147483648;
    localparam logic [32:0]        CH_SAT  = 33'h07FFFFFFF;

    // configuration registers
    logic [SIZE_W-1:0] x_size_reg, y_size_reg, z_size_reg;
    logic [FACE_W-1:0] faces_reg;
    logic [SRC_W-1:0]  source_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_size_reg <= SIZE_W'(MAX_X);
            y_size_reg <= SIZE_W'(MAX_Y);
            z_size_reg <= SIZE_W'(MAX_Z);
            faces_reg  <= '1;
            source_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_X_SIZE: x_size_reg <= cfg_data[SIZE_W-1:0];
                REG_Y_SIZE: y_size_reg <= cfg_data[SIZE_W-1:0];
                REG_Z_SIZE: z_size_reg <= cfg_data[SIZE_W-1:0];
                REG_FACES:  faces_reg  <= cfg_data[FACE_W-1:0];
                REG_SOURCE: source_reg <= cfg_data[SRC_W-1:0];
                default:    ;
            endcase
        end
    end

    // effective sizes and update box
    logic [SIZE_W-1:0] nx, ny, nz;
    logic [SIZE_W-1:0] lox, hix, loy, hiy, loz, hiz;

    assign nx  = clamp_size(x_size_reg, SIZE_W'(MAX_X));
    assign ny  = clamp_size(y_size_reg, SIZE_W'(MAX_Y));
    assign nz  = clamp_size(z_size_reg, SIZE_W'(MAX_Z));
    assign lox = SIZE_W'(1) + SIZE_W'(faces_reg[0]);
    assign hix = nx - SIZE_W'(2) - SIZE_W'(faces_reg[1]);
    assign loy = SIZE_W'(1) + SIZE_W'(faces_reg[2]);
    assign hiy = ny - SIZE_W'(2) - SIZE_W'(faces_reg[3]);
    assign loz = SIZE_W'(1) + SIZE_W'(faces_reg[4]);
    assign hiz = nz - SIZE_W'(2) - SIZE_W'(faces_reg[5]);

    // scan position of the waiting beat
    logic [XW-1:0] pos_x_reg, pos_y_reg_x;
    logic [YW-1:0] pos_y_reg;
    logic [ZW-1:0] pos_z_reg;
    logic          restart;
    logic [XW-1:0] cur_x, nxt_x;
    logic [YW-1:0] cur_y, nxt_y;
    logic [ZW-1:0] cur_z, nxt_z;
    logic [SIZE_W-1:0] x_inc, y_inc, z_inc, cz7;

    assign pos_y_reg_x = '0;
    assign restart = sweep_start
                   || ({1'b0, pos_x_reg} >= nx)
                   || ({1'b0, pos_y_reg} >= ny)
                   || ({1'b0, pos_z_reg} >= nz);
    assign cur_x = restart ? pos_y_reg_x : pos_x_reg;
    assign cur_y = restart ? '0 : pos_y_reg;
    assign cur_z = restart ? '0 : pos_z_reg;
    assign x_inc = {1'b0, cur_x} + SIZE_W'(1);
    assign y_inc = {1'b0, cur_y} + SIZE_W'(1);
    assign z_inc = {1'b0, cur_z} + SIZE_W'(1);
    assign cz7   = {1'b0, cur_z} - SIZE_W'(1);

    // next position in scan order
    always_comb
    begin
        nxt_x = x_inc[XW-1:0];
        nxt_y = cur_y;
        nxt_z = cur_z;
        if (x_inc >= nx)
        begin
            nxt_x = '0;
            if (y_inc >= ny)
            begin
                nxt_y = '0;
                if (z_inc >= nz)
                    nxt_z = '0;
                else
                    nxt_z = z_inc[ZW-1:0];
            end
            else
                nxt_y = y_inc[YW-1:0];
        end
    end

    // box test and sideband for this beat
    js3d_meta_t cur_meta;
    logic       in_box;

    assign in_box = (cur_z != '0)
                 && ({1'b0, cur_x} >= lox) && ({1'b0, cur_x} <= hix)
                 && ({1'b0, cur_y} >= loy) && ({1'b0, cur_y} <= hiy)
                 && (cz7 >= loz) && (cz7 <= hiz);
    assign cur_meta.clr  = (cur_x == '0) && (cur_y == '0) && (cur_z == '0);
    assign cur_meta.hit  = in_box;
    assign cur_meta.last = ({1'b0, cur_x} == hix) && ({1'b0, cur_y} == hiy)
                        && (cz7 == hiz);
    assign cur_meta.px   = cur_x;
    assign cur_meta.py   = cur_y;
    assign cur_meta.pz   = cz7[ZW-1:0];

    // window addresses: {plane parity, y, x}
    logic              prev_plane;
    logic [WIN_AW-1:0] here_addr, ym_addr, yp_addr, cen_addr, pf_addr, b1_addr;

    assign prev_plane = ~cur_z[0];
    assign here_addr  = {cur_z[0], cur_y, cur_x};
    assign ym_addr    = {prev_plane, cur_y - YW'(1), cur_x};
    assign yp_addr    = {prev_plane, cur_y + YW'(1), cur_x};
    assign cen_addr   = {prev_plane, cur_y, cur_x};
    assign pf_addr    = {~nxt_z[0], nxt_y, nxt_x};

    // handshake and centre prefetch check
    logic              advance, accept, reread, pf_hit;
    logic [WIN_AW-1:0] pf_tag_reg;
    logic              pf_ok_reg;
    logic              s7_valid_reg;
    js3d_meta_t        s7_meta_reg;
    logic              out_valid_reg;

    assign advance  = !(s7_valid_reg && s7_meta_reg.hit && out_valid_reg && !out_ready);
    assign pf_hit   = pf_ok_reg && (pf_tag_reg == cen_addr);
    assign in_ready = advance && pf_hit;
    assign accept   = in_valid && in_ready;
    assign reread   = in_valid && advance && !pf_hit;
    assign b1_addr  = accept ? pf_addr : cen_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            pos_z_reg  <= '0;
            pf_tag_reg <= '0;
            pf_ok_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pos_x_reg <= nxt_x;
                pos_y_reg <= nxt_y;
                pos_z_reg <= nxt_z;
            end
            if (accept || reread)
            begin
                pf_tag_reg <= b1_addr;
                pf_ok_reg  <= 1'b1;
            end
        end
    end

    // plane window, two copies for four reads a cycle
    logic [VALUE_BITS-1:0] rd_below, rd_ym, rd_yp, rd_b1;

    js3d_ram #(.WIDTH(VALUE_BITS), .DEPTH(WIN_DEPTH)) u_win_a (
        .clk    (clk),
        .we     (accept),
        .waddr  (here_addr),
        .wdata  (old_value),
        .re0    (accept),
        .raddr0 (here_addr),
        .rdata0 (rd_below),
        .re1    (accept),
        .raddr1 (ym_addr),
        .rdata1 (rd_ym)
    );

    js3d_ram #(.WIDTH(VALUE_BITS), .DEPTH(WIN_DEPTH)) u_win_b (
        .clk    (clk),
        .we     (accept),
        .waddr  (here_addr),
        .wdata  (old_value),
        .re0    (accept),
        .raddr0 (yp_addr),
        .rdata0 (rd_yp),
        .re1    (accept || reread),
        .raddr1 (b1_addr),
        .rdata1 (rd_b1)
    );

    // pipeline valid bits
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    // stage payloads
    js3d_meta_t s1_meta_reg, s2_meta_reg, s3_meta_reg, s4_meta_reg;
    js3d_meta_t s5_meta_reg, s6_meta_reg;
    logic signed [VALUE_BITS-1:0] s1_v_reg, s1_cen_reg, s1_xm_reg, prev_cen_reg;
    logic signed [VALUE_BITS-1:0] s2_old_reg, s3_old_reg, s4_old_reg;
    logic signed [VALUE_BITS-1:0] s5_old_reg, s6_old_reg;
    logic signed [32:0]  s2_p0_reg, s2_p1_reg;
    logic signed [33:0]  s2_p2_reg;
    logic signed [35:0]  t_sum, u_half, w_full;
    logic [34:0]         s3_w_reg;
    logic [17:0]         d2_res, d1_res, d0_res;
    logic [1:0]          s4_q2_reg, s4_r_reg, s5_q2_reg, s5_r_reg, s6_q2_reg;
    logic [31:0]         s4_lo_reg;
    logic [15:0]         s5_lo_reg, s5_q1_reg, s6_q1_reg, s6_q0_reg;
    logic [33:0]         quot;
    logic signed [34:0]  r_full;
    logic signed [VALUE_BITS-1:0] nv_sat;
    logic signed [32:0]  diff;
    logic [32:0]         diff_abs;
    logic [CHANGE_W-1:0] ch;
    logic signed [VALUE_BITS-1:0] s7_nv_reg;
    logic [CHANGE_W-1:0] s7_ch_reg;

    // sum of six neighbours and source, split in two levels
    assign t_sum  = 36'(s2_p0_reg) + 36'(s2_p1_reg) + 36'(s2_p2_reg);
    assign u_half = t_sum >>> 1;
    assign w_full = u_half + W_BIAS;

    // division by three, one 16-bit digit per stage
    assign d2_res = div3_step(2'b00, {13'b0, s3_w_reg[34:32]});
    assign d1_res = div3_step(s4_r_reg, s4_lo_reg[31:16]);
    assign d0_res = div3_step(s5_r_reg, s5_lo_reg);

    // unbias, saturate and measure the change
    assign quot     = {s6_q2_reg, s6_q1_reg, s6_q0_reg};
    assign r_full   = $signed({1'b0, quot}) - Q_BIAS;
    assign nv_sat   = (r_full > V_MAX) ? VALUE_BITS'(V_MAX)
                    : (r_full < V_MIN) ? VALUE_BITS'(V_MIN)
                    : r_full[VALUE_BITS-1:0];
    assign diff     = 33'(nv_sat) - 33'(s6_old_reg);
    assign diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
    assign ch       = (diff_abs > CH_SAT) ? CH_SAT[CHANGE_W-1:0] : diff_abs[CHANGE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (accept)
            begin
                s1_meta_reg  <= cur_meta;
                s1_v_reg     <= old_value;
                s1_cen_reg   <= rd_b1;
                s1_xm_reg    <= prev_cen_reg;
                prev_cen_reg <= rd_b1;
            end
            s2_meta_reg <= s1_meta_reg;
            s2_old_reg  <= s1_cen_reg;
            s2_p0_reg   <= 33'(s1_xm_reg) + 33'($signed(rd_b1));
            s2_p1_reg   <= 33'($signed(rd_ym)) + 33'($signed(rd_yp));
            s2_p2_reg   <= 34'($signed(rd_below)) + 34'(s1_v_reg)
                         + $signed({3'b0, source_reg}) + 34'sd3;
            s3_meta_reg <= s2_meta_reg;
            s3_old_reg  <= s2_old_reg;
            s3_w_reg    <= w_full[34:0];
            s4_meta_reg <= s3_meta_reg;
            s4_old_reg  <= s3_old_reg;
            s4_q2_reg   <= d2_res[3:2];
            s4_r_reg    <= d2_res[1:0];
            s4_lo_reg   <= s3_w_reg[31:0];
            s5_meta_reg <= s4_meta_reg;
            s5_old_reg  <= s4_old_reg;
            s5_q2_reg   <= s4_q2_reg;
            s5_q1_reg   <= d1_res[17:2];
            s5_r_reg    <= d1_res[1:0];
            s5_lo_reg   <= s4_lo_reg[15:0];
            s6_meta_reg <= s5_meta_reg;
            s6_old_reg  <= s5_old_reg;
            s6_q2_reg   <= s5_q2_reg;
            s6_q1_reg   <= s5_q1_reg;
            s6_q0_reg   <= d0_res[17:2];
            s7_meta_reg <= s6_meta_reg;
            s7_nv_reg   <= nv_sat;
            s7_ch_reg   <= ch;
        end
    end

    // running maximum, cleared at the start of a sweep
    logic [CHANGE_W-1:0] max_reg, max_base, max_next;

    assign max_base = s7_meta_reg.clr ? '0 : max_reg;
    assign max_next = (s7_meta_reg.hit && (s7_ch_reg > max_base)) ? s7_ch_reg : max_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance && s7_valid_reg)
                max_reg <= max_next;
            if (advance && s7_valid_reg && s7_meta_reg.hit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // output register
    logic signed [VALUE_BITS-1:0] out_nv_reg;
    logic [XW-1:0]       out_x_reg;
    logic [YW-1:0]       out_y_reg;
    logic [ZW-1:0]       out_z_reg;
    logic [CHANGE_W-1:0] out_ch_reg, out_max_reg;
    logic                out_last_reg;

    always_ff @(posedge clk)
    begin
        if (advance && s7_valid_reg && s7_meta_reg.hit)
        begin
            out_nv_reg   <= s7_nv_reg;
            out_x_reg    <= s7_meta_reg.px;
            out_y_reg    <= s7_meta_reg.py;
            out_z_reg    <= s7_meta_reg.pz;
            out_ch_reg   <= s7_ch_reg;
            out_max_reg  <= max_next;
            out_last_reg <= s7_meta_reg.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign new_value     = out_nv_reg;
    assign point_x       = out_x_reg;
    assign point_y       = out_y_reg;
    assign point_z       = out_z_reg;
    assign abs_change    = out_ch_reg;
    assign max_change    = out_max_reg;
    assign last_of_sweep = out_last_reg;

endmodule

FILE: dv/jacobi_stencil_3d_sweep_test.sv
// jacobi_stencil_3d_sweep_test: self-checking bench for the streamed 3d jacobi stencil
// depends on js3d_pkg and jacobi_stencil_3d_sweep; needs no files or arguments

module jacobi_stencil_3d_sweep_test;
    import js3d_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 600;
    localparam int HOLD_AT        = 460;
    localparam int PAUSE_AT       = 540;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam logic signed [31:0] V_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] V_MIN = 32'sh80000000;
    localparam logic [30:0]        CH_MAX = 31'h7fffffff;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic signed [VALUE_BITS-1:0] old_value;
    logic                         sweep_start;
    logic                         out_valid;
    logic                         out_ready;
    logic signed [VALUE_BITS-1:0] new_value;
    logic [XW-1:0]                point_x;
    logic [YW-1:0]                point_y;
    logic [ZW-1:0]                point_z;
    logic [CHANGE_W-1:0]          abs_change;
    logic [CHANGE_W-1:0]          max_change;
    logic                         last_of_sweep;
    logic                         cfg_write;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_W-1:0]             cfg_data;

    jacobi_stencil_3d_sweep dut (.*);

    // one updated grid point
    typedef struct packed {
        logic signed [31:0] nv;
        logic [5:0]         x;
        logic [5:0]         y;
        logic [5:0]         z;
        logic [30:0]        ch;
        logic [30:0]        mx;
        logic               last;
    } point_upd_t;

    // one run of identical beats in the directed table
    typedef struct {
        logic signed [31:0] val;
        int                 count;
        bit                 typed;
        logic signed [31:0] exp_nv;
        logic [30:0]        exp_ch;
    } run_t;

    point_upd_t pending_updates[$];
    int         errors;
    int         idle_cycles;
    bit         hold_request;
    bit         valid_on;
    int         burst_left;
    bit         no_idle;

    // shadow of the registers and the stencil state
    logic [6:0]         sz_x, sz_y, sz_z;
    logic [5:0]         faces;
    logic [30:0]        src;
    logic signed [31:0] win [WIN_DEPTH];
    int                 px, py, pz;
    logic [30:0]        run_max;

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    function automatic int clamp_axis(input logic [6:0] s, input int hi);
        return s < 3 ? 3 : (s > hi ? hi : int'(s));
    endfunction

    function automatic int win_slot(input int x, input int y, input int z);
        return ((z & 1) * MAX_Y + y) * MAX_X + x;
    endfunction

    function automatic longint floor_div(input longint a, input longint d,
                                         output longint r);
        longint q;
        q = a / d;
        r = a % d;
        if (r < 0)
        begin
            q -= 1;
            r += d;
        end
        return q;
    endfunction

    // rounded sixth of seven terms, ties up, saturated to 32 bits
    function automatic longint stencil_mean(input longint t [7]);
        longint hi_sum, lo_sum, r, ra, qa, d, maxv, minv;
        hi_sum = 0;
        lo_sum = 0;
        for (int i = 0; i < 7; i++)
        begin
            hi_sum += floor_div(t[i], 8, r);
            lo_sum += r;
        end
        qa   = floor_div(hi_sum, 3, ra);
        d    = (8 * ra + lo_sum + 3) / 6;
        maxv = 64'sd2147483647;
        minv = -maxv - 1;
        if (qa > (maxv - d) / 4)
            return maxv;
        if (qa < minv / 4 - d / 4)
            return minv;
        return qa * 4 + d;
    endfunction

    // advance the shadow stencil by one beat
    task automatic predict_point(input logic signed [31:0] v, input logic st,
                                 output bit hit, output point_upd_t u);
        int     nx, ny, nz, lox, hix, loy, hiy, loz, hiz, x, y, z, here;
        longint t [7];
        longint oldv, nv, diff;
        nx  = clamp_axis(sz_x, MAX_X);
        ny  = clamp_axis(sz_y, MAX_Y);
        nz  = clamp_axis(sz_z, MAX_Z);
        lox = 1 + faces[0];
        hix = nx - 2 - faces[1];
        loy = 1 + faces[2];
        hiy = ny - 2 - faces[3];
        loz = 1 + faces[4];
        hiz = nz - 2 - faces[5];
        hit = 0;
        u   = '0;
        if (st || px >= nx || py >= ny || pz >= nz)
        begin
            px = 0;
            py = 0;
            pz = 0;
        end
        if (px == 0 && py == 0 && pz == 0)
            run_max = '0;
        x = px;
        y = py;
        z = pz;
        here = win_slot(x, y, z);
        if (z >= 1 && x >= lox && x <= hix && y >= loy && y <= hiy &&
            z - 1 >= loz && z - 1 <= hiz)
        begin
            t[0] = win[win_slot(x - 1, y, z - 1)];
            t[1] = win[win_slot(x + 1, y, z - 1)];
            t[2] = win[win_slot(x, y - 1, z - 1)];
            t[3] = win[win_slot(x, y + 1, z - 1)];
            t[4] = win[here];
            t[5] = v;
            t[6] = longint'(src);
            oldv = win[win_slot(x, y, z - 1)];
            nv   = stencil_mean(t);
            diff = nv >= oldv ? nv - oldv : oldv - nv;
            u.ch = diff > longint'(CH_MAX) ? CH_MAX : diff[30:0];
            if (u.ch > run_max)
                run_max = u.ch;
            u.nv   = nv[31:0];
            u.x    = x[5:0];
            u.y    = y[5:0];
            u.z    = 6'(z - 1);
            u.mx   = run_max;
            u.last = (x == hix && y == hiy && z - 1 == hiz);
            hit    = 1;
        end
        win[here] = v;
        px = x + 1;
        if (px >= nx)
        begin
            px = 0;
            py = y + 1;
            if (py >= ny)
            begin
                py = 0;
                pz = z + 1;
                if (pz >= nz)
                    pz = 0;
            end
        end
    endtask

    // register write, mirrored into the shadow
    task automatic cfg_set(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_X_SIZE: sz_x  = data[6:0];
            REG_Y_SIZE: sz_y  = data[6:0];
            REG_Z_SIZE: sz_z  = data[6:0];
            REG_FACES:  faces = data[5:0];
            REG_SOURCE: src   = data[30:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [6:0] x, input logic [6:0] y, input logic [6:0] z,
                             input logic [5:0] f, input logic [30:0] s);
        cfg_set(REG_X_SIZE, CFG_W'(x));
        cfg_set(REG_Y_SIZE, CFG_W'(y));
        cfg_set(REG_Z_SIZE, CFG_W'(z));
        cfg_set(REG_FACES, CFG_W'(f));
        cfg_set(REG_SOURCE, s);
        cfg_set(REG_SPARE, CFG_W'($urandom));
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // drop valid and wait for every expected update, optionally then drain
    task automatic settle(input bit drain);
        if (valid_on)
            in_valid <= 1'b0;
        valid_on = 0;
        while (pending_updates.size() != 0)
            @(posedge clk);
        if (drain)
            repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // offer one beat, predict on acceptance, then pace the sender
    task automatic push(input logic signed [31:0] val, input logic st, input bit typed,
                        input logic signed [31:0] exp_nv, input logic [30:0] exp_ch);
        point_upd_t u;
        bit         hit;
        int         gap;
        in_valid    <= 1'b1;
        old_value   <= val;
        sweep_start <= st;
        valid_on = 1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_point(val, st, hit, u);
        if (hit)
        begin
            if (typed)
            begin
                u.nv   = exp_nv;
                u.ch   = exp_ch;
                u.last = 1'b1;
            end
            pending_updates.push_back(u);
        end
        if (no_idle || burst_left > 0)
        begin
            if (burst_left > 0)
                burst_left--;
        end
        else
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            valid_on = 0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(0, 20);
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 15))
            0: return V_MAX;
            1: return V_MIN;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [6:0] pick_size(input bit wide);
        return wide ? 7'($urandom_range(0, 127)) : 7'($urandom_range(3, 7));
    endfunction

    // result checking and receiver stalls
    int      stall_mode;
    int      rx_cycle;
    int      hold_left;
    initial
    begin
        stall_mode = 0;
        rx_cycle   = 0;
        hold_left  = 0;
    end

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    always @(posedge clk)
    begin
        point_upd_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_updates.size() == 0)
                report("update beat with nothing expected");
            else
            begin
                w = pending_updates.pop_front();
                check_field("new_value", longint'(new_value), longint'(w.nv));
                check_field("point_x", point_x, w.x);
                check_field("point_y", point_y, w.y);
                check_field("point_z", point_z, w.z);
                check_field("abs_change", abs_change, w.ch);
                check_field("max_change", max_change, w.mx);
                check_field("last_of_sweep", last_of_sweep, w.last);
            end
        end
        rx_cycle++;
        if (rx_cycle % 50 == 0)
            stall_mode = $urandom_range(0, 2);
        if (hold_request)
        begin
            hold_request = 0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        run_t       runs [2];
        int         random_done, phase, n_items, sweep_len, wide_axis;
        logic [6:0] cx, cy, cz;
        logic [5:0] cf;
        logic [30:0] cs;
        logic       st;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        old_value   = '0;
        sweep_start = 1'b0;
        out_ready   = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        errors      = 0;
        idle_cycles = 0;
        hold_request = 0;
        valid_on    = 0;
        burst_left  = 0;
        no_idle     = 0;
        sz_x  = 7'd64;
        sz_y  = 7'd64;
        sz_z  = 7'd64;
        faces = 6'd63;
        src   = '0;
        px = 0;
        py = 0;
        pz = 0;
        run_max = '0;
        foreach (win[i])
            win[i] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: smallest grid with a single interior point, full source term
        runs[0] = '{V_MAX, 23, 1'b1, V_MAX, 31'd0};
        runs[1] = '{V_MIN, 23, 1'b0, 32'sd0, 31'd0};
        configure(7'd3, 7'd3, 7'd3, 6'd0, CH_MAX);
        foreach (runs[r])
            for (int i = 0; i < runs[r].count; i++)
                push(runs[r].val, i == 0, runs[r].typed, runs[r].exp_nv, runs[r].exp_ch);
        settle(1);

        // random phases, the first one pinned to the widest x and clamped low y and z
        random_done = 0;
        phase = 0;
        while (random_done < RANDOM_ITEMS)
        begin
            case (phase)
                0: begin cx = 7'd127; cy = 7'd2; cz = 7'd1; cf = 6'd0; cs = CH_MAX; end
                default:
                begin
                    wide_axis = $urandom_range(0, 7);
                    cx = pick_size(wide_axis == 0);
                    cy = pick_size(wide_axis == 1);
                    cz = pick_size(wide_axis == 2);
                    cf = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'd0;
                    cs = $urandom_range(0, 3) == 0 ? CH_MAX : 31'($urandom);
                end
            endcase
            configure(cx, cy, cz, cf, cs);
            no_idle = ($urandom_range(0, 3) == 0);
            sweep_len = clamp_axis(sz_x, MAX_X) * clamp_axis(sz_y, MAX_Y) *
                        clamp_axis(sz_z, MAX_Z);
            n_items = sweep_len * (sweep_len > 150 ? 1 : $urandom_range(1, 3));
            if (phase == 0)
                no_idle = 1;
            for (int i = 0; i < n_items; i++)
            begin
                // mostly whole sweeps, now and then a restart mid-sweep
                st = (i == 0) || (phase != 0 && $urandom_range(0, 59) == 0);
                push(pick_value(), st, 1'b0, 32'sd0, 31'd0);
                // long receiver hold once results are flowing
                if (phase == 0 && i == HOLD_AT)
                    hold_request = 1;
                if (phase == 0 && i == PAUSE_AT)
                    settle(0);
            end
            random_done += n_items;
            settle(1);
            phase++;
        end

        settle(1);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
